@@ hdl/fp64_add_sub_mul_div_unit_core_defines.svh @@
// Assertion helpers for the fp64 unit.
`ifndef FP64_ADD_SUB_MUL_DIV_UNIT_CORE_DEFINES_SVH
`define FP64_ADD_SUB_MUL_DIV_UNIT_CORE_DEFINES_SVH

`ifndef SYNTH
`define FP64U_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("fp64u check failed");
`define FP64U_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("fp64u check failed");
`else
`define FP64U_ASSERT_IMPL(lbl, ck, rstn, ante, cons)
`define FP64U_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif

`endif

@@ hdl/fp64u_pkg.sv @@
package fp64u_pkg;

	localparam int DIV_GUARD_BITS = 8;
	localparam int DIV_ITERS      = 52 + DIV_GUARD_BITS;
	localparam int QUO_W          = 62;
	localparam int DIV_KEPT       = (DIV_ITERS + 1 < QUO_W) ? DIV_ITERS + 1 : QUO_W;
	localparam int EXP_W          = 14;

	localparam logic [62:0] INF_MAG  = 63'h7FF0000000000000;
	localparam logic [62:0] NAN_MAG  = 63'h7FF0000000000001;
	localparam logic [63:0] NAN_BITS = {1'b0, NAN_MAG};

	typedef logic signed [EXP_W-1:0] exp_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic             vld;
		op_t              op;
		logic             spec;
		logic [63:0]      spec_bits;
		logic             sign;
		exp_t             exp;
		logic [63:0]      sig;
		logic [52:0]      rem;
		logic [52:0]      dvs;
		logic [QUO_W-1:0] quo;
		logic             stk;
	} pipe_t;

	function automatic logic [6:0] lzc64(input logic [63:0] x);
		logic [6:0] n;
		logic       found;
		n = 7'd64;
		found = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!found && x[i]) begin
				n = 7'(63 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// right shift, lost bits collapse into bit 0
	function automatic logic [63:0] shr_jam64(input logic [63:0] x, input logic [12:0] d);
		logic [63:0] mask;
		logic [63:0] r;
		mask = '0;
		if (d >= 13'd64) begin
			r = {63'b0, |x};
		end else begin
			mask = ~({64{1'b1}} << d[5:0]);
			r = (x >> d[5:0]) | {63'b0, |(x & mask)};
		end
		return r;
	endfunction

endpackage

@@ hdl/fp64_add_sub_mul_div_unit_core.sv @@
// Every operation takes the same path (5 front stages, 52 + DIV_GUARD_BITS
// division stages, 4 rounding stages); add, sub and mul ride the same depth.
// Throughput: one transfer per cycle; the whole pipeline holds while a result
// waits under out_stall.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
`include "fp64_add_sub_mul_div_unit_core_defines.svh"

module fp64_add_sub_mul_div_unit_core import fp64u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_bits
);

	logic  en;
	pipe_t chain [DIV_ITERS+1];

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	fp64u_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.op        (op),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_st    (chain[0])
	);

	for (genvar i = 1; i <= DIV_ITERS; i++) begin : g_div
		fp64u_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.shift_in (1'(i < QUO_W)),
			.in_st    (chain[i-1]),
			.out_st   (chain[i])
		);
	end

	fp64u_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_st    (chain[DIV_ITERS]),
		.out_vld  (out_valid),
		.out_bits (result_bits)
	);

	`FP64U_ASSERT_NEXT(a_hold_front, clk, arst_n, in_stall, $stable(chain[0]))
	`FP64U_ASSERT_NEXT(a_last_to_out, clk, arst_n, chain[DIV_ITERS-1].vld && !in_stall, chain[DIV_ITERS].vld)
	`FP64U_ASSERT_NEXT(a_bubble_to_out, clk, arst_n, !chain[DIV_ITERS-1].vld && !in_stall, !chain[DIV_ITERS].vld)

endmodule

@@ hdl/fp64u_front.sv @@
module fp64u_front import fp64u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [1:0]  op,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output pipe_t       out_st
);

	typedef struct packed {
		logic        vld;
		op_t         op;
		logic        spec;
		logic [63:0] spec_bits;
		logic        sign;
		logic        sub;
		logic [62:0] x1;
		logic [62:0] x2;
	} s1_t;

	typedef struct packed {
		logic        vld;
		op_t         op;
		logic        spec;
		logic [63:0] spec_bits;
		logic        sign;
		logic        sub;
		logic [52:0] sig1;
		logic [52:0] sig2;
		exp_t        e1;
		exp_t        e2;
		logic [5:0]  lz1;
		logic [5:0]  lz2;
	} s2_t;

	typedef struct packed {
		logic        vld;
		op_t         op;
		logic        spec;
		logic [63:0] spec_bits;
		logic        sign;
		logic        sub;
		logic [63:0] g1;
		logic [63:0] g2;
		exp_t        e1;
		exp_t        e2;
	} s3_t;

	typedef struct packed {
		logic        vld;
		op_t         op;
		logic        spec;
		logic [63:0] spec_bits;
		logic        sign;
		exp_t        exp;
		logic [63:0] sum;
		logic [63:0] p00;
		logic [63:0] p01;
		logic [63:0] p10;
		logic [63:0] p11;
		logic [52:0] rem;
		logic [52:0] dvs;
	} s4_t;

	s1_t   st_s1, n1;
	s2_t   st_s2, n2;
	s3_t   st_s3, n3;
	s4_t   st_s4, n4;
	pipe_t st_s5, n5;

	// stage 1: special operands, add/sub operand swap
	logic [63:0] b_eff;
	logic        sa, sb, sx;
	logic [62:0] ma, mb;
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

	always_comb begin
		b_eff  = (op_t'(op) == OP_SUB) ? {~operand_b[63], operand_b[62:0]} : operand_b;
		sa     = operand_a[63];
		sb     = b_eff[63];
		sx     = sa ^ sb;
		ma     = operand_a[62:0];
		mb     = b_eff[62:0];
		nan_a  = ma > INF_MAG;
		nan_b  = mb > INF_MAG;
		inf_a  = ma == INF_MAG;
		inf_b  = mb == INF_MAG;
		zero_a = ma == '0;
		zero_b = mb == '0;
		n1     = '0;
		n1.vld = in_valid;
		n1.op  = op_t'(op);
		n1.sub = sx;
		unique case (op_t'(op))
			OP_ADD, OP_SUB: begin
				n1.spec = 1'b1;
				priority if (nan_a || nan_b) begin
					n1.spec_bits = NAN_BITS;
				end else if (inf_a && inf_b) begin
					n1.spec_bits = sx ? NAN_BITS : operand_a;
				end else if (inf_a) begin
					n1.spec_bits = operand_a;
				end else if (inf_b) begin
					n1.spec_bits = b_eff;
				end else if (zero_a && zero_b) begin
					n1.spec_bits = sx ? 64'b0 : operand_a;
				end else if (zero_a) begin
					n1.spec_bits = b_eff;
				end else if (zero_b) begin
					n1.spec_bits = operand_a;
				end else if (ma == mb && sx) begin
					n1.spec_bits = 64'b0;
				end else begin
					n1.spec = 1'b0;
					n1.spec_bits = 64'b0;
				end
				if (ma < mb) begin
					n1.x1 = mb;
					n1.x2 = ma;
					n1.sign = sb;
				end else begin
					n1.x1 = ma;
					n1.x2 = mb;
					n1.sign = sa;
				end
			end
			OP_MUL: begin
				n1.spec = 1'b1;
				priority if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
					n1.spec_bits = {sx, NAN_MAG};
				end else if (inf_a || inf_b) begin
					n1.spec_bits = {sx, INF_MAG};
				end else if (zero_a || zero_b) begin
					n1.spec_bits = {sx, 63'b0};
				end else begin
					n1.spec = 1'b0;
					n1.spec_bits = 64'b0;
				end
				n1.x1 = ma;
				n1.x2 = mb;
				n1.sign = sx;
			end
			OP_DIV: begin
				n1.spec = 1'b1;
				priority if (nan_a || nan_b || (zero_a && zero_b) || (inf_a && inf_b)) begin
					n1.spec_bits = {sx, NAN_MAG};
				end else if (inf_a || zero_b) begin
					n1.spec_bits = {sx, INF_MAG};
				end else if (zero_a || inf_b) begin
					n1.spec_bits = {sx, 63'b0};
				end else begin
					n1.spec = 1'b0;
					n1.spec_bits = 64'b0;
				end
				n1.x1 = ma;
				n1.x2 = mb;
				n1.sign = sx;
			end
		endcase
	end

	// stage 2: unpack, leading zero count for subnormals
	logic [10:0] ef1, ef2;
	logic [6:0]  lzr1, lzr2;

	always_comb begin
		ef1 = st_s1.x1[62:52];
		ef2 = st_s1.x2[62:52];
		n2 = '0;
		n2.vld = st_s1.vld;
		n2.op = st_s1.op;
		n2.spec = st_s1.spec;
		n2.spec_bits = st_s1.spec_bits;
		n2.sign = st_s1.sign;
		n2.sub = st_s1.sub;
		n2.sig1 = {ef1 != 11'd0, st_s1.x1[51:0]};
		n2.sig2 = {ef2 != 11'd0, st_s1.x2[51:0]};
		n2.e1 = (ef1 == 11'd0) ? -exp_t'(1074) : $signed({3'b0, ef1}) - exp_t'(1075);
		n2.e2 = (ef2 == 11'd0) ? -exp_t'(1074) : $signed({3'b0, ef2}) - exp_t'(1075);
		lzr1 = lzc64({11'b0, n2.sig1}) - 7'd11;
		lzr2 = lzc64({11'b0, n2.sig2}) - 7'd11;
		n2.lz1 = lzr1[5:0];
		n2.lz2 = lzr2[5:0];
	end

	// stage 3: normalize (mul/div) or align (add/sub)
	logic [63:0] nm1, nm2;
	exp_t        ne1, ne2;
	exp_t        ediff;

	always_comb begin
		nm1 = {11'b0, st_s2.sig1} << st_s2.lz1;
		nm2 = {11'b0, st_s2.sig2} << st_s2.lz2;
		ne1 = st_s2.e1 - $signed({8'b0, st_s2.lz1});
		ne2 = st_s2.e2 - $signed({8'b0, st_s2.lz2});
		ediff = st_s2.e1 - st_s2.e2;
		n3 = '0;
		n3.vld = st_s2.vld;
		n3.op = st_s2.op;
		n3.spec = st_s2.spec;
		n3.spec_bits = st_s2.spec_bits;
		n3.sign = st_s2.sign;
		n3.sub = st_s2.sub;
		unique case (st_s2.op)
			OP_ADD, OP_SUB: begin
				n3.g1 = {1'b0, st_s2.sig1, 10'b0};
				n3.g2 = shr_jam64({1'b0, st_s2.sig2, 10'b0}, ediff[12:0]);
				n3.e1 = st_s2.e1 - exp_t'(10);
				n3.e2 = st_s2.e2;
			end
			OP_MUL: begin
				n3.g1 = {1'b0, nm1[52:0], 10'b0};
				n3.g2 = {nm2[52:0], 11'b0};
				n3.e1 = ne1;
				n3.e2 = ne2;
			end
			OP_DIV: begin
				n3.g1 = {11'b0, nm1[52:0]};
				n3.g2 = {11'b0, nm2[52:0]};
				n3.e1 = ne1;
				n3.e2 = ne2;
			end
		endcase
	end

	// stage 4: add/sub, partial products, first quotient bit
	logic        lt;
	logic [53:0] xs, dif;

	always_comb begin
		lt = st_s3.g1[52:0] < st_s3.g2[52:0];
		xs = lt ? {st_s3.g1[52:0], 1'b0} : {1'b0, st_s3.g1[52:0]};
		dif = xs - {1'b0, st_s3.g2[52:0]};
		n4 = '0;
		n4.vld = st_s3.vld;
		n4.op = st_s3.op;
		n4.spec = st_s3.spec;
		n4.spec_bits = st_s3.spec_bits;
		n4.sign = st_s3.sign;
		n4.sum = st_s3.sub ? st_s3.g1 - st_s3.g2 : st_s3.g1 + st_s3.g2;
		n4.p00 = {32'b0, st_s3.g1[31:0]} * {32'b0, st_s3.g2[31:0]};
		n4.p01 = {32'b0, st_s3.g1[31:0]} * {32'b0, st_s3.g2[63:32]};
		n4.p10 = {32'b0, st_s3.g1[63:32]} * {32'b0, st_s3.g2[31:0]};
		n4.p11 = {32'b0, st_s3.g1[63:32]} * {32'b0, st_s3.g2[63:32]};
		n4.rem = dif[52:0];
		n4.dvs = st_s3.g2[52:0];
		unique case (st_s3.op)
			OP_ADD, OP_SUB: n4.exp = st_s3.e1;
			OP_MUL:         n4.exp = st_s3.e1 + st_s3.e2 + exp_t'(43);
			OP_DIV:         n4.exp = st_s3.e1 - st_s3.e2 - $signed({13'b0, lt});
		endcase
	end

	// stage 5: product sum
	logic [127:0] prod;

	always_comb begin
		prod = {st_s4.p11, st_s4.p00} + {32'b0, st_s4.p01, 32'b0} + {32'b0, st_s4.p10, 32'b0};
		n5 = '0;
		n5.vld = st_s4.vld;
		n5.op = st_s4.op;
		n5.spec = st_s4.spec;
		n5.spec_bits = st_s4.spec_bits;
		n5.sign = st_s4.sign;
		n5.exp = st_s4.exp;
		n5.sig = (st_s4.op == OP_MUL) ? {prod[127:65], prod[64] | (|prod[63:0])} : st_s4.sum;
		n5.rem = st_s4.rem;
		n5.dvs = st_s4.dvs;
		n5.quo = {{(QUO_W-1){1'b0}}, 1'b1};
		n5.stk = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1.vld <= 1'b0;
			st_s2.vld <= 1'b0;
			st_s3.vld <= 1'b0;
			st_s4.vld <= 1'b0;
			st_s5.vld <= 1'b0;
		end else if (en) begin
			st_s1 <= n1;
			st_s2 <= n2;
			st_s3 <= n3;
			st_s4 <= n4;
			st_s5 <= n5;
		end
	end

	assign out_st = st_s5;

endmodule

@@ hdl/fp64u_div_stage.sv @@
module fp64u_div_stage import fp64u_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  shift_in,
	input  pipe_t in_st,
	output pipe_t out_st
);

	pipe_t       pipe_s1, nxt;
	logic [53:0] r2, rs;
	logic        ge;

	// one restoring quotient bit
	always_comb begin
		r2 = {in_st.rem, 1'b0};
		ge = r2 >= {1'b0, in_st.dvs};
		rs = ge ? r2 - {1'b0, in_st.dvs} : r2;
		nxt = in_st;
		nxt.rem = rs[52:0];
		if (shift_in) begin
			nxt.quo = {in_st.quo[QUO_W-2:0], ge};
		end else begin
			nxt.stk = in_st.stk | ge;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s1.vld <= 1'b0;
		end else if (en) begin
			pipe_s1 <= nxt;
		end
	end

	assign out_st = pipe_s1;

endmodule

@@ hdl/fp64u_round.sv @@
module fp64u_round import fp64u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  pipe_t       in_st,
	output logic        out_vld,
	output logic [63:0] out_bits
);

	typedef struct packed {
		logic        vld;
		logic        spec;
		logic [63:0] spec_bits;
		logic        sign;
		exp_t        exp;
		logic [63:0] sig;
		logic [5:0]  lz;
	} r1_t;

	typedef struct packed {
		logic        vld;
		logic        spec;
		logic [63:0] spec_bits;
		logic        sign;
		exp_t        bexp;
		logic [63:0] sig;
	} r2_t;

	typedef struct packed {
		logic        vld;
		logic        spec;
		logic [63:0] spec_bits;
		logic        sign;
		logic        ovf;
		logic [10:0] base;
		logic [63:0] sig;
	} r3_t;

	r1_t         st_s1, n1;
	r2_t         st_s2, n2;
	r3_t         st_s3, n3;
	logic        vld_s4;
	logic [63:0] res_s4;
	logic [6:0]  lzr;

	// quotient assembly, leading zero count
	always_comb begin
		n1.vld = in_st.vld;
		n1.spec = in_st.spec;
		n1.spec_bits = in_st.spec_bits;
		n1.sign = in_st.sign;
		if (in_st.op == OP_DIV) begin
			n1.sig = {1'b0, in_st.quo, in_st.stk | (|in_st.rem)};
			n1.exp = in_st.exp - exp_t'(DIV_KEPT);
		end else begin
			n1.sig = in_st.sig;
			n1.exp = in_st.exp;
		end
		lzr = lzc64(n1.sig);
		n1.lz = lzr[5:0];
	end

	always_comb begin
		n2.vld = st_s1.vld;
		n2.spec = st_s1.spec;
		n2.spec_bits = st_s1.spec_bits;
		n2.sign = st_s1.sign;
		n2.sig = st_s1.sig << st_s1.lz;
		n2.bexp = st_s1.exp - $signed({8'b0, st_s1.lz}) + exp_t'(1086);
	end

	// subnormal denormalize
	logic den;
	exp_t dsh, bm1;

	always_comb begin
		den = st_s2.bexp <= exp_t'(0);
		dsh = exp_t'(1) - st_s2.bexp;
		bm1 = st_s2.bexp - exp_t'(1);
		n3.vld = st_s2.vld;
		n3.spec = st_s2.spec;
		n3.spec_bits = st_s2.spec_bits;
		n3.sign = st_s2.sign;
		n3.ovf = st_s2.bexp >= exp_t'(2047);
		n3.base = den ? 11'd0 : bm1[10:0];
		n3.sig = den ? shr_jam64(st_s2.sig, dsh[12:0]) : st_s2.sig;
	end

	// round to nearest even, pack
	logic [10:0] rb;
	logic        inc;
	logic [63:0] bits;
	logic [63:0] res;

	always_comb begin
		rb = st_s3.sig[10:0];
		inc = (rb > 11'h400) || (rb == 11'h400 && st_s3.sig[11]);
		bits = {1'b0, st_s3.base, 52'b0} + {11'b0, st_s3.sig[63:11]} + {63'b0, inc};
		priority if (st_s3.spec) begin
			res = st_s3.spec_bits;
		end else if (st_s3.ovf || bits[62:52] == 11'h7FF) begin
			res = {st_s3.sign, INF_MAG};
		end else begin
			res = {st_s3.sign, bits[62:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1.vld <= 1'b0;
			st_s2.vld <= 1'b0;
			st_s3.vld <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			st_s1 <= n1;
			st_s2 <= n2;
			st_s3 <= n3;
			vld_s4 <= st_s3.vld;
			res_s4 <= res;
		end
	end

	assign out_vld = vld_s4;
	assign out_bits = res_s4;

endmodule
